FILE: design/buzzer_melody_sequencer_core_assert.svh
// assertion macros used by the sequencer step module
`ifndef BUZZER_MELODY_SEQUENCER_CORE_ASSERT_SVH
`define BUZZER_MELODY_SEQUENCER_CORE_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define BMS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sequencer invariant violated");

// consequent must hold in the same cycle as the antecedent
`define BMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer implication violated");

`endif

FILE: design/bms_pkg.sv
package bms_pkg;

    // action codes of an input item
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_BEEP = 2'd1;
    localparam logic [1:0] ACT_PLAY = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_FREQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_DUR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ID    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_ID     = 3'd4;

    // configuration reset values
    localparam logic [15:0] BEEP_FREQ_RST = 16'd2700;
    localparam logic [15:0] BEEP_DUR_RST  = 16'd100;
    localparam logic [7:0]  GOAL_ID_RST   = 8'd0;
    localparam logic [7:0]  ACK_ID_RST    = 8'd1;

    // melody selection and tone table
    localparam logic MEL_GOAL = 1'b0;
    localparam logic MEL_ACK  = 1'b1;
    localparam int POS_W = 3;
    localparam int REP_W = 3;
    localparam int GOAL_LEN = 5;
    localparam int ACK_LEN  = 3;

    localparam logic [15:0] GOAL_HZ [GOAL_LEN] = '{16'd2700, 16'd0, 16'd3200, 16'd0, 16'd2700};
    localparam logic [7:0]  GOAL_MS [GOAL_LEN] = '{8'd90, 8'd50, 8'd110, 8'd50, 8'd160};
    localparam logic [15:0] ACK_HZ  [ACK_LEN]  = '{16'd2700, 16'd0, 16'd2700};
    localparam logic [7:0]  ACK_MS  [ACK_LEN]  = '{8'd70, 8'd35, 8'd70};

    typedef struct packed {
        logic        enabled;
        logic [15:0] beep_freq_hz;
        logic [15:0] beep_duration_ms;
        logic [7:0]  goal_melody_id;
        logic [7:0]  ack_melody_id;
    } t_cfg;

    typedef struct packed {
        logic [15:0] tone_hz;
        logic        accepted;
        logic        busy_res;
    } t_result;

    // number of tones in the selected melody
    function automatic logic [POS_W-1:0] melody_len(input logic sel);
        return (sel == MEL_ACK) ? POS_W'(ACK_LEN) : POS_W'(GOAL_LEN);
    endfunction

    // frequency of one tone, silent outside the melody
    function automatic logic [15:0] tone_hz(input logic sel, input logic [POS_W-1:0] pos);
        logic [15:0] hz;
        hz = '0;
        if (sel == MEL_ACK) begin
            if (pos < POS_W'(ACK_LEN)) hz = ACK_HZ[pos[1:0]];
        end else begin
            if (pos < POS_W'(GOAL_LEN)) hz = GOAL_HZ[pos];
        end
        return hz;
    endfunction

    // duration of one tone in milliseconds
    function automatic logic [7:0] tone_ms(input logic sel, input logic [POS_W-1:0] pos);
        logic [7:0] ms;
        ms = '0;
        if (sel == MEL_ACK) begin
            if (pos < POS_W'(ACK_LEN)) ms = ACK_MS[pos[1:0]];
        end else begin
            if (pos < POS_W'(GOAL_LEN)) ms = GOAL_MS[pos];
        end
        return ms;
    endfunction

endpackage

FILE: design/bms_cfg_regs.sv
module bms_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    output bms_pkg::t_cfg                  o_cfg
);

    bms_pkg::t_cfg r_cfg;

    // writes are always accepted
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register file, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled          <= 1'b0;
            r_cfg.beep_freq_hz     <= bms_pkg::BEEP_FREQ_RST;
            r_cfg.beep_duration_ms <= bms_pkg::BEEP_DUR_RST;
            r_cfg.goal_melody_id   <= bms_pkg::GOAL_ID_RST;
            r_cfg.ack_melody_id    <= bms_pkg::ACK_ID_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bms_pkg::CFG_ENABLED:   r_cfg.enabled          <= i_cfg_data[0];
                bms_pkg::CFG_BEEP_FREQ: r_cfg.beep_freq_hz     <= i_cfg_data;
                bms_pkg::CFG_BEEP_DUR:  r_cfg.beep_duration_ms <= i_cfg_data;
                bms_pkg::CFG_GOAL_ID:   r_cfg.goal_melody_id   <= i_cfg_data[7:0];
                bms_pkg::CFG_ACK_ID:    r_cfg.ack_melody_id    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: design/bms_step.sv
module bms_step #(
    parameter int MAX_REPEATS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [1:0]            i_action,
    input  logic [7:0]            i_melody_id,
    input  logic [7:0]            i_repeat_count,
    input  bms_pkg::t_cfg         i_cfg,
    output bms_pkg::t_result      o_result
);

    localparam int PW = bms_pkg::POS_W;
    localparam int RW = bms_pkg::REP_W;

    // sequencer state
    logic [31:0]   r_ms_counter,    n_ms_counter;
    logic          r_beep_active,   n_beep_active;
    logic [31:0]   r_beep_deadline, n_beep_deadline;
    logic          r_melody_active, n_melody_active;
    logic          r_melody_select, n_melody_select;
    logic [PW-1:0] r_tone_position, n_tone_position;
    logic [RW-1:0] r_repeats_left,  n_repeats_left;
    logic [31:0]   r_tone_deadline, n_tone_deadline;
    logic [15:0]   r_current_freq,  n_current_freq;

    logic [31:0]   ms_inc;
    logic [31:0]   beep_diff;
    logic [31:0]   tone_diff;
    logic          beep_reached;
    logic          tone_reached;
    logic [PW-1:0] pos_inc;
    logic          pass_done;
    logic [PW-1:0] next_pos;
    logic [RW-1:0] rep_dec;
    logic          id_goal;
    logic          id_known;
    logic          play_sel;
    logic [RW-1:0] rep_clamped;
    logic          acc;

    // deadline checks against the counter after the tick
    assign ms_inc       = r_ms_counter + 32'd1;
    assign beep_diff    = ms_inc - r_beep_deadline;
    assign tone_diff    = ms_inc - r_tone_deadline;
    assign beep_reached = ~beep_diff[31];
    assign tone_reached = ~tone_diff[31];

    // next tone within the melody
    assign pos_inc   = r_tone_position + PW'(1);
    assign pass_done = (pos_inc >= bms_pkg::melody_len(r_melody_select));
    assign next_pos  = pass_done ? '0 : pos_inc;
    assign rep_dec   = r_repeats_left - RW'(1);

    // play command decode
    assign id_goal  = (i_melody_id == i_cfg.goal_melody_id);
    assign id_known = id_goal || (i_melody_id == i_cfg.ack_melody_id);
    assign play_sel = id_goal ? bms_pkg::MEL_GOAL : bms_pkg::MEL_ACK;

    // repeat count: zero plays once, capped at the maximum
    always_comb begin
        priority if (i_repeat_count == 8'd0) begin
            rep_clamped = RW'(1);
        end else if (i_repeat_count > 8'(MAX_REPEATS)) begin
            rep_clamped = RW'(MAX_REPEATS);
        end else begin
            rep_clamped = i_repeat_count[RW-1:0];
        end
    end

    // next state for one item
    always_comb begin
        n_ms_counter    = r_ms_counter;
        n_beep_active   = r_beep_active;
        n_beep_deadline = r_beep_deadline;
        n_melody_active = r_melody_active;
        n_melody_select = r_melody_select;
        n_tone_position = r_tone_position;
        n_repeats_left  = r_repeats_left;
        n_tone_deadline = r_tone_deadline;
        n_current_freq  = r_current_freq;
        acc             = 1'b0;
        unique case (i_action)
            bms_pkg::ACT_TICK: begin
                n_ms_counter = ms_inc;
                if (r_beep_active && beep_reached) begin
                    n_current_freq = '0;
                    n_beep_active  = 1'b0;
                end
                if (!n_beep_active && r_melody_active && tone_reached) begin
                    if (pass_done && rep_dec == '0) begin
                        n_melody_active = 1'b0;
                        n_melody_select = bms_pkg::MEL_GOAL;
                        n_tone_position = '0;
                        n_repeats_left  = '0;
                        n_tone_deadline = '0;
                        n_current_freq  = '0;
                    end else begin
                        if (pass_done) n_repeats_left = rep_dec;
                        n_tone_position = next_pos;
                        n_current_freq  = bms_pkg::tone_hz(r_melody_select, next_pos);
                        n_tone_deadline = ms_inc
                            + 32'(bms_pkg::tone_ms(r_melody_select, next_pos));
                    end
                end
            end
            bms_pkg::ACT_BEEP: begin
                if (i_cfg.enabled) begin
                    n_melody_active = 1'b0;
                    n_melody_select = bms_pkg::MEL_GOAL;
                    n_tone_position = '0;
                    n_repeats_left  = '0;
                    n_tone_deadline = '0;
                    n_current_freq  = i_cfg.beep_freq_hz;
                    n_beep_deadline = r_ms_counter + 32'(i_cfg.beep_duration_ms);
                    n_beep_active   = 1'b1;
                end
            end
            bms_pkg::ACT_PLAY: begin
                if (i_cfg.enabled && id_known) begin
                    n_beep_active   = 1'b0;
                    n_melody_active = 1'b1;
                    n_melody_select = play_sel;
                    n_tone_position = '0;
                    n_repeats_left  = rep_clamped;
                    n_current_freq  = bms_pkg::tone_hz(play_sel, '0);
                    n_tone_deadline = r_ms_counter + 32'(bms_pkg::tone_ms(play_sel, '0));
                    acc             = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // result of this item
    assign o_result.tone_hz  = n_current_freq;
    assign o_result.accepted = acc;
    assign o_result.busy_res = n_beep_active || n_melody_active;

    // state update when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_counter    <= '0;
            r_beep_active   <= 1'b0;
            r_beep_deadline <= '0;
            r_melody_active <= 1'b0;
            r_melody_select <= bms_pkg::MEL_GOAL;
            r_tone_position <= '0;
            r_repeats_left  <= '0;
            r_tone_deadline <= '0;
            r_current_freq  <= '0;
        end else if (i_fire) begin
            r_ms_counter    <= n_ms_counter;
            r_beep_active   <= n_beep_active;
            r_beep_deadline <= n_beep_deadline;
            r_melody_active <= n_melody_active;
            r_melody_select <= n_melody_select;
            r_tone_position <= n_tone_position;
            r_repeats_left  <= n_repeats_left;
            r_tone_deadline <= n_tone_deadline;
            r_current_freq  <= n_current_freq;
        end
    end

    `include "buzzer_melody_sequencer_core_assert.svh"

    // a beep and a melody never sound together
    `BMS_ASSERT_ALWAYS(a_beep_melody_excl, i_clk, i_rst_n, !(r_beep_active && r_melody_active))
    // a running melody stays inside its table with passes left
    `BMS_ASSERT_IMPL(a_melody_in_range, i_clk, i_rst_n, r_melody_active, (r_tone_position < bms_pkg::melody_len(r_melody_select)) && (r_repeats_left != '0) && (r_repeats_left <= RW'(MAX_REPEATS)))
    // an idle melody is fully cleared
    `BMS_ASSERT_IMPL(a_melody_cleared, i_clk, i_rst_n, !r_melody_active, (r_tone_position == '0) && (r_repeats_left == '0) && (r_tone_deadline == '0))
    // nothing sounding means silence
    `BMS_ASSERT_IMPL(a_idle_silent, i_clk, i_rst_n, !r_beep_active && !r_melody_active, r_current_freq == '0)

endmodule

FILE: design/bms_out_reg.sv
module bms_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bms_pkg::t_result  i_result,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output bms_pkg::t_result  o_result
);

    logic             r_valid;
    bms_pkg::t_result r_result;

    // free when empty or when the held item leaves this cycle
    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: design/buzzer_melody_sequencer_core.sv
// path: an input item is accepted into the input register, then passes the
// sequencer logic into the result register, where its result is valid
// throughput: one item per cycle; the input register holds one item while
// the result register is stalled
// reset: synchronous active-low i_rst_n clears the handshake, the sequencer
// state and the configuration registers to their defaults
module buzzer_melody_sequencer_core #(
    parameter int MAX_REPEATS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic [7:0]                     i_melody_id,
    input  logic [7:0]                     i_repeat_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [15:0]                    o_tone_hz,
    output logic                           o_accepted,
    output logic                           o_busy_res
);

    logic             r_in_valid;
    logic [1:0]       r_action;
    logic [7:0]       r_melody_id;
    logic [7:0]       r_repeat_count;
    logic             out_can_load;
    logic             fire;
    bms_pkg::t_cfg    cfg;
    bms_pkg::t_result step_result;
    bms_pkg::t_result out_result;

    // item moves from the input register to the result register
    assign fire       = r_in_valid && out_can_load;
    assign o_in_ready = !r_in_valid || fire;

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action       <= i_action;
            r_melody_id    <= i_melody_id;
            r_repeat_count <= i_repeat_count;
        end
    end

    bms_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bms_step #(
        .MAX_REPEATS (MAX_REPEATS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_action       (r_action),
        .i_melody_id    (r_melody_id),
        .i_repeat_count (r_repeat_count),
        .i_cfg          (cfg),
        .o_result       (step_result)
    );

    bms_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (step_result),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_tone_hz  = out_result.tone_hz;
    assign o_accepted = out_result.accepted;
    assign o_busy_res = out_result.busy_res;

endmodule
